@@ rtl/shmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmt_pkg: shared types and constants of the height median tracker
// Store geometry, sample type, command codes, register indexes and states.
// ----------------------------------------------------------------------------
package shmt_pkg;

	localparam int MAX_SAMPLES = 128;
	localparam int SAMPLE_BITS = 20;

	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int REG_W = 7;
	localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	// Readout tree: groups of eight cells, then one pick among the groups.
	localparam int PICK_LOG_G = 3;
	localparam int PICK_G = 1 << PICK_LOG_G;
	localparam int PICK_NGRP = (MAX_SAMPLES + PICK_G - 1) / PICK_G;
	localparam int PICK_GRP_W = (PICK_NGRP > 1) ? $clog2(PICK_NGRP) : 1;
	localparam int PICK_NSEL = 1 << PICK_GRP_W;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	localparam logic [1:0] REG_REPORT_EVERY = 2'd0;
	localparam logic [1:0] REG_TOTAL_SAMPLES = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_GATHER = 2'd1,
		ST_PICK   = 2'd2
	} state_t;

	// Insertion broadcast seen by every cell of the chain.
	typedef struct packed {
		logic              en;
		sample_t           x;
		logic [CNT_W-1:0]  count;
	} ins_t;

endpackage

@@ rtl/sampled_height_median_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_height_median_tracker: running upper median of height samples
// Sorted insertion chain with a registered readout of the median.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_ group: s_tuser carries the command (add
// sample, start session, end session) and s_tdata the signed height sample.
// A start command empties the store and arms collection; an end command
// disarms it. Each added sample is placed in the sorted chain in the cycle it
// is accepted, every cell deciding locally whether to keep its value, shift
// in its left neighbor's, or take the new sample.
// Results leave on the m_ group: m_tdata holds the upper median and m_tlast
// marks the final report of a session, after which collection has stopped.
// An item that causes no result is taken and the next item may follow at
// once. An item that causes a report holds off the next item while the
// block inserts it, runs the first stage of the readout tree over the
// cells, and loads the output register.
// The report reaches m_tvalid through the first readout stage and the output
// register, and waits only while the output register holds an earlier report.
// If the receiver stalls with a result still held, the block waits in its
// last readout step until the output register is free; otherwise the held
// result and the next accepted items proceed independently.
// The configuration channel is always ready; writes go to report_every
// (index 0) and total_samples (index 1), other indexes are ignored.
// Reset clears the sample count, the countdown and the collecting flag, and
// loads report_every with 10 and total_samples with 100. The sample cells
// need no reset: only cells below the sample count are ever read.
// ----------------------------------------------------------------------------
module sampled_height_median_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items. s_tdata: [19:0] height_sample. s_tuser: [1:0] cmd.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [shmt_pkg::TDATA_W-1:0]    s_tdata,
	input  logic [1:0]                      s_tuser,
	// Result items. m_tdata: [19:0] median_height. m_tlast: is_final.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [shmt_pkg::TDATA_W-1:0]    m_tdata,
	output logic                            m_tlast,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [shmt_pkg::REG_W-1:0]      cfg_data
);

	shmt_pkg::state_t state_q, state_d;

	logic [shmt_pkg::REG_W-1:0] report_every_q;
	logic [shmt_pkg::REG_W-1:0] total_q;
	logic [shmt_pkg::REG_W-1:0] countdown_q;
	logic [shmt_pkg::CNT_W-1:0] count_q;
	logic                       collecting_q;
	logic                       final_q;
	logic [shmt_pkg::IDX_W-1:0] med_idx_q;

	logic                       m_tvalid_q;
	shmt_pkg::sample_t          m_data_q;
	logic                       m_last_q;

	logic                       in_acc;
	shmt_pkg::cmd_t             cmd;
	shmt_pkg::sample_t          sample;
	logic                       do_insert;
	logic [shmt_pkg::CNT_W-1:0] count_new;
	logic                       rep_tick;
	logic                       rep_final;
	logic                       report;
	logic                       load_out;

	shmt_pkg::ins_t             ins;
	shmt_pkg::sample_t          cell_val [shmt_pkg::MAX_SAMPLES];
	logic                       cell_gt  [shmt_pkg::MAX_SAMPLES];
	shmt_pkg::sample_t          med;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign cmd       = shmt_pkg::cmd_t'(s_tuser);
	assign sample    = shmt_pkg::sample_t'(s_tdata[shmt_pkg::SAMPLE_BITS-1:0]);

	// A sample is stored only while collecting and while the store has room.
	assign do_insert = in_acc && (cmd == shmt_pkg::CMD_ADD) && collecting_q &&
		(count_q != shmt_pkg::CNT_W'(shmt_pkg::MAX_SAMPLES));
	assign count_new = count_q + shmt_pkg::CNT_W'(1);
	// A countdown of zero or one means this sample is due for a report.
	assign rep_tick  = countdown_q <= shmt_pkg::REG_W'(1);
	assign rep_final = shmt_pkg::CMP_W'(count_new) > shmt_pkg::CMP_W'(total_q);
	assign report    = do_insert && (rep_tick || rep_final);

	assign ins.en    = do_insert;
	assign ins.x     = sample;
	assign ins.count = count_q;

	// The chain of cells: cell zero has no left neighbor.
	for (genvar i = 0; i < shmt_pkg::MAX_SAMPLES; i++) begin : g_cell
		shmt_cell u_cell (
			.clk      (clk),
			.ins      (ins),
			.cell_idx (shmt_pkg::IDX_W'(i)),
			.left_val ((i == 0) ? shmt_pkg::sample_t'('0) : cell_val[(i == 0) ? 0 : i - 1]),
			.left_gt  ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	shmt_pick u_pick (
		.clk     (clk),
		.vals    (cell_val),
		.med_idx (med_idx_q),
		.med     (med)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_every_q <= shmt_pkg::REG_W'(10);
			total_q        <= shmt_pkg::REG_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				shmt_pkg::REG_REPORT_EVERY:  report_every_q <= cfg_data;
				shmt_pkg::REG_TOTAL_SAMPLES: total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Session state: count, countdown, collecting flag, pending report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			countdown_q  <= '0;
			collecting_q <= 1'b0;
			final_q      <= 1'b0;
			med_idx_q    <= '0;
		end else if (in_acc) begin
			case (cmd)
				shmt_pkg::CMD_START: begin
					count_q      <= '0;
					collecting_q <= 1'b1;
					countdown_q  <= report_every_q;
				end
				shmt_pkg::CMD_STOP: begin
					collecting_q <= 1'b0;
				end
				shmt_pkg::CMD_ADD: begin
					if (do_insert) begin
						count_q   <= count_new;
						med_idx_q <= shmt_pkg::IDX_W'(count_new >> 1);
						final_q   <= rep_final;
						if (rep_tick) begin
							countdown_q <= report_every_q;
						end else begin
							countdown_q <= countdown_q - shmt_pkg::REG_W'(1);
						end
						if (rep_final) begin
							collecting_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer: insert, first readout stage, then load the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shmt_pkg::ST_IDLE:   if (report) state_d = shmt_pkg::ST_GATHER;
			shmt_pkg::ST_GATHER: state_d = shmt_pkg::ST_PICK;
			shmt_pkg::ST_PICK:   if (!m_tvalid_q || m_tready) state_d = shmt_pkg::ST_IDLE;
			default:             state_d = shmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			shmt_pkg::ST_IDLE: s_tready = 1'b1;
			shmt_pkg::ST_PICK: load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= med;
			m_last_q <= final_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = shmt_pkg::TDATA_W'($unsigned(m_data_q));
	assign m_tlast  = m_last_q;

	// The sample count never runs past the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= shmt_pkg::CNT_W'(shmt_pkg::MAX_SAMPLES))
		else $error("sample count exceeds store depth");

	// The readout is entered only straight from an insert.
	a_gather_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shmt_pkg::ST_GATHER) |-> $past(state_q == shmt_pkg::ST_IDLE))
		else $error("readout entered without an insert");

	// A final report is loaded only once collection has stopped.
	a_final_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && final_q) |-> !collecting_q)
		else $error("final report while still collecting");

	// A new result appears only after the last readout step.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == shmt_pkg::ST_PICK))
		else $error("result without readout");

endmodule

@@ rtl/shmt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmt_cell: one slot of the sorted insertion chain
// Holds one sample; on an insert it keeps, shifts in its left neighbor, or
// takes the new sample.
// ----------------------------------------------------------------------------
module shmt_cell (
	input  logic                           clk,
	input  shmt_pkg::ins_t                 ins,
	input  logic [shmt_pkg::IDX_W-1:0]     cell_idx,
	input  shmt_pkg::sample_t              left_val,
	input  logic                           left_gt,
	output shmt_pkg::sample_t              val,
	output logic                           gt
);

	shmt_pkg::sample_t val_q;
	logic occ;
	logic tail;

	assign occ  = shmt_pkg::CNT_W'(cell_idx) < ins.count;
	assign tail = shmt_pkg::CNT_W'(cell_idx) == ins.count;
	assign gt   = occ && (val_q > ins.x);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ins.en) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || tail) begin
				val_q <= ins.x;
			end
		end
	end

endmodule

@@ rtl/shmt_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shmt_pick: registered readout tree over the chain
// The first stage picks one cell of each group into registers; the second
// stage selects the group and feeds the output register.
// ----------------------------------------------------------------------------
module shmt_pick (
	input  logic                           clk,
	input  shmt_pkg::sample_t              vals [shmt_pkg::MAX_SAMPLES],
	input  logic [shmt_pkg::IDX_W-1:0]     med_idx,
	output shmt_pkg::sample_t              med
);

	localparam int WIDE_W = shmt_pkg::IDX_W + shmt_pkg::PICK_LOG_G;

	shmt_pkg::sample_t pad [shmt_pkg::PICK_NSEL * shmt_pkg::PICK_G];
	shmt_pkg::sample_t grp_s1 [shmt_pkg::PICK_NSEL];
	logic [shmt_pkg::PICK_GRP_W-1:0] hi_s1;
	logic [WIDE_W-1:0] idx_w;
	logic [shmt_pkg::PICK_LOG_G-1:0] lo;

	assign idx_w = WIDE_W'(med_idx);
	assign lo    = idx_w[shmt_pkg::PICK_LOG_G-1:0];

	always_comb begin
		for (int i = 0; i < shmt_pkg::PICK_NSEL * shmt_pkg::PICK_G; i++) begin
			pad[i] = (i < shmt_pkg::MAX_SAMPLES) ? vals[i] : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < shmt_pkg::PICK_NSEL; g++) begin
			grp_s1[g] <= pad[g * shmt_pkg::PICK_G + int'(lo)];
		end
		hi_s1 <= shmt_pkg::PICK_GRP_W'(idx_w >> shmt_pkg::PICK_LOG_G);
	end

	assign med = grp_s1[hi_s1];

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the height median tracker
// Sends session commands and height samples on the input stream, predicts
// every median report from its own copy of the sorted store, and compares the
// output stream item by item, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int N_RANDOM = 650;
	// Once every report is out the block is idle again; SETTLE_CYCLES spare
	// cycles separate the last item from a register write.
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 400;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		shmt_pkg::sample_t median;
		logic              last;
	} report_t;

	// One directed step: an optional register update before it, the item,
	// and the report it must produce.
	typedef struct packed {
		logic                       reconf;
		logic [shmt_pkg::REG_W-1:0] every;
		logic [shmt_pkg::REG_W-1:0] total;
		logic [1:0]                 cmd;
		shmt_pkg::sample_t          height;
		logic                       has_report;
		shmt_pkg::sample_t          median;
		logic                       last;
	} step_row_t;

	localparam int N_ROWS = 26;
	localparam step_row_t STEP_ROWS [N_ROWS] = '{
		// Reset settings: a report every 10 samples, 100 samples in total.
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd5,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, CMD_UNUSED,          -20'sd1,      1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_STOP,  20'sd0,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_START, 20'sd0,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd10,      1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd9,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd8,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd7,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd6,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd5,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd4,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd3,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd2,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd1,       1'b1, 20'sd6,       1'b0},
		// A lower total mid-session ends collection at the next sample.
		'{1'b1, 7'd1, 7'd3, shmt_pkg::CMD_ADD,   20'sd0,       1'b1, 20'sd5,       1'b1},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_START, 20'sd0,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd524287,  1'b1, 20'sd524287,  1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   -20'sd524288, 1'b1, 20'sd524287,  1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd0,       1'b1, 20'sd0,       1'b0},
		// Intermediate and final at once: a single report marked final.
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   -20'sd1,      1'b1, 20'sd0,       1'b1},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_START, 20'sd0,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   -20'sd524288, 1'b1, -20'sd524288, 1'b0},
		// Start while collecting empties the store again.
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_START, 20'sd0,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd100,     1'b1, 20'sd100,     1'b0},
		// Interval and total of zero: the first sample gives a final report.
		'{1'b1, 7'd0, 7'd0, shmt_pkg::CMD_START, 20'sd0,       1'b0, 20'sd0,       1'b0},
		'{1'b0, 7'd0, 7'd0, shmt_pkg::CMD_ADD,   20'sd3,       1'b1, 20'sd3,       1'b1}
	};

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [shmt_pkg::TDATA_W-1:0] s_tdata = '0;
	logic [1:0]                   s_tuser = shmt_pkg::CMD_ADD;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [shmt_pkg::TDATA_W-1:0] m_tdata;
	logic                         m_tlast;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [1:0]                   cfg_index = shmt_pkg::REG_REPORT_EVERY;
	logic [shmt_pkg::REG_W-1:0]   cfg_data = '0;

	// Predicted tracker state and register copies.
	shmt_pkg::sample_t          sorted_heights [shmt_pkg::MAX_SAMPLES];
	int unsigned                height_count = 0;
	logic                       armed = 1'b0;
	int unsigned                countdown = 0;
	logic [shmt_pkg::REG_W-1:0] every_reg = 7'd10;
	logic [shmt_pkg::REG_W-1:0] total_reg = 7'd100;

	report_t pending_reports [$];
	int      mismatches = 0;
	int      items_done = 0;
	int      rx_hold = 0;
	logic    calm = 1'b0;

	sampled_height_median_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

	// Applies one accepted item to the predicted state. The median is the
	// entry at index count/2 after insertion.
	task automatic track_median(input logic [1:0] cmd, input shmt_pkg::sample_t x,
			output logic has, output report_t rep, output logic counted);
		int unsigned i;
		has = 1'b0;
		rep = '0;
		counted = 1'b0;
		if (cmd == shmt_pkg::CMD_START) begin
			height_count = 0;
			armed = 1'b1;
			countdown = every_reg;
			counted = 1'b1;
		end else if (cmd == shmt_pkg::CMD_STOP) begin
			armed = 1'b0;
			counted = 1'b1;
		end else if (cmd == shmt_pkg::CMD_ADD && armed &&
				height_count < shmt_pkg::MAX_SAMPLES) begin
			counted = 1'b1;
			i = height_count;
			while (i > 0 && sorted_heights[i-1] > x) begin
				sorted_heights[i] = sorted_heights[i-1];
				i--;
			end
			sorted_heights[i] = x;
			height_count++;
			if (countdown <= 1) begin
				has = 1'b1;
				countdown = every_reg;
			end else begin
				countdown--;
			end
			if (height_count > total_reg) begin
				has = 1'b1;
				rep.last = 1'b1;
				armed = 1'b0;
			end
			if (has)
				rep.median = sorted_heights[height_count / 2];
		end
	endtask

	// Offers one item, waits for it to be taken and records what it should
	// produce. A typed row overrides the prediction with its own result.
	task automatic send_item(input logic [1:0] cmd, input shmt_pkg::sample_t x,
			input logic typed = 1'b0, input logic typed_has = 1'b0,
			input report_t typed_rep = '0);
		logic    has;
		report_t rep;
		logic    counted;
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(shmt_pkg::TDATA_W - shmt_pkg::SAMPLE_BITS){1'b0}}, x};
		do @(posedge clk); while (!s_tready);
		track_median(cmd, x, has, rep, counted);
		if (typed) begin
			has = typed_has;
			rep = typed_rep;
		end
		if (has)
			pending_reports.push_back(rep);
		if (counted)
			items_done++;
	endtask

	// Stops sending and waits until every report is in and the block is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index,
			input logic [shmt_pkg::REG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == shmt_pkg::REG_REPORT_EVERY)
			every_reg = value;
		else if (index == shmt_pkg::REG_TOTAL_SAMPLES)
			total_reg = value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [shmt_pkg::REG_W-1:0] every,
			input logic [shmt_pkg::REG_W-1:0] total);
		drain();
		write_reg(shmt_pkg::REG_REPORT_EVERY, every);
		write_reg(shmt_pkg::REG_TOTAL_SAMPLES, total);
	endtask

	// Mostly full-range heights, with extremes and a narrow band for ties.
	function automatic shmt_pkg::sample_t rand_height();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return {1'b0, {(shmt_pkg::SAMPLE_BITS - 1){1'b1}}};
		if (roll < 16)
			return {1'b1, {(shmt_pkg::SAMPLE_BITS - 1){1'b0}}};
		if (roll < 40)
			return shmt_pkg::sample_t'(int'($urandom_range(16)) - 8);
		return shmt_pkg::sample_t'($urandom());
	endfunction

	function automatic logic [shmt_pkg::REG_W-1:0] rand_reg(input int unsigned typical);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return '0;
		if (roll < 12)
			return '1;
		if (roll < 20)
			return 7'd1;
		return shmt_pkg::REG_W'($urandom_range(typical, 1));
	endfunction

	// A session runs mostly to its final report, with a stray stop, restart
	// or unused code now and then, and sometimes a register change partway.
	task automatic run_session();
		int          n_adds;
		int          split_at;
		int unsigned roll;
		send_item(shmt_pkg::CMD_START, rand_height());
		if ($urandom_range(99) < 75)
			n_adds = int'(total_reg) + 1;
		else
			n_adds = $urandom_range(int'(total_reg) + 3);
		split_at = ($urandom_range(3) == 0) ? $urandom_range(n_adds) : -1;
		for (int k = 0; k < n_adds; k++) begin
			if (k == split_at)
				configure(rand_reg(6), rand_reg(24));
			roll = $urandom_range(99);
			if (roll < 3)
				send_item(CMD_UNUSED, rand_height());
			else if (roll < 5)
				send_item(shmt_pkg::CMD_STOP, rand_height());
			else if (roll < 7)
				send_item(shmt_pkg::CMD_START, rand_height());
			send_item(shmt_pkg::CMD_ADD, rand_height());
		end
		if ($urandom_range(1) == 0)
			send_item(shmt_pkg::CMD_STOP, rand_height());
		repeat ($urandom_range(2)) send_item(shmt_pkg::CMD_ADD, rand_height());
	endtask

	// Receiver: random stalls, none while calm, and a counted long hold.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 33);
		end
	end

	// Each taken report is checked against the oldest prediction.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report: median_height %0d is_final %0b",
					$signed(m_tdata[shmt_pkg::SAMPLE_BITS-1:0]), m_tlast);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[shmt_pkg::SAMPLE_BITS-1:0] !== want.median) begin
					$error("median_height: expected %0d, got %0d",
						want.median, $signed(m_tdata[shmt_pkg::SAMPLE_BITS-1:0]));
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("is_final: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		report_t row_rep;
		int      session_no;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (STEP_ROWS[r].reconf) begin
				drain();
				write_reg(shmt_pkg::REG_REPORT_EVERY, STEP_ROWS[r].every);
				write_reg(shmt_pkg::REG_TOTAL_SAMPLES, STEP_ROWS[r].total);
			end
			row_rep.median = STEP_ROWS[r].median;
			row_rep.last = STEP_ROWS[r].last;
			send_item(STEP_ROWS[r].cmd, STEP_ROWS[r].height, 1'b1,
				STEP_ROWS[r].has_report, row_rep);
		end

		items_done = 0;
		session_no = 0;
		while (items_done < N_RANDOM) begin
			if (session_no == 3) begin
				// Report on every sample of a full store while the receiver
				// holds off, so the block backs up and stalls its input.
				configure(7'd1, '1);
				rx_hold = HOLD_CYCLES;
			end else begin
				configure(rand_reg(6), rand_reg(24));
			end
			calm = (session_no >= 6 && session_no < 10);
			run_session();
			session_no++;
		end
		calm = 1'b0;

		drain();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
